// ===== rtl/core/bitmap_row_run_spans_defines.svh =====
// assertion macros for the bitmap row run span extractor
// used by the top level; expects clk and rst in scope
`ifndef BITMAP_ROW_RUN_SPANS_DEFINES_SVH
`define BITMAP_ROW_RUN_SPANS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BRRS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BRRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/brrs_pkg.sv =====
// shared constants, types and helpers for the bitmap row run span extractor
// no dependencies; imported by every module of the block
package brrs_pkg;

  // row geometry and lane split (ROW_WIDTH must be a multiple of NUM_LANES)
  localparam int ROW_WIDTH = 24;
  localparam int NUM_LANES = 4;
  localparam int LANE_COLS = ROW_WIDTH / NUM_LANES;
  localparam int COL_W     = $clog2(ROW_WIDTH + 1);

  // field widths
  localparam int BITS_W    = 24;
  localparam int ROWNUM_W  = 5;
  localparam int ORIGIN_W  = 10;
  localparam int COLOUR_W  = 16;
  localparam int COORD_W   = 12;
  localparam int RWIDTH_W  = 9;
  localparam int SCALE_W   = 5;

  // scale limits and reset, width clamp
  localparam int SCALE_MAX   = 16;
  localparam int SCALE_RESET = 4;
  localparam int WIDTH_MAX   = 511;

  // per-row fields carried alongside the bitmap
  typedef struct packed {
    logic [ROWNUM_W-1:0]        row_number;
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
    logic [COLOUR_W-1:0]        fill_colour;
  } item_t;

  // one rectangle command
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RWIDTH_W-1:0]       width;
    logic [SCALE_W-1:0]        height;
    logic [COLOUR_W-1:0]       colour;
    logic                      last;
  } rect_t;

  // run edges found by one lane, bit 0 is the lane's leftmost column
  typedef struct packed {
    logic [LANE_COLS-1:0] start;
    logic [LANE_COLS-1:0] stop;
  } lane_flags_t;

  // zero acts as one, anything above the maximum clamps
  function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] raw);
    logic [SCALE_W-1:0] s;
    if (raw == '0) begin
      s = SCALE_W'(1);
    end else if (raw > SCALE_W'(SCALE_MAX)) begin
      s = SCALE_W'(SCALE_MAX);
    end else begin
      s = raw;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/brrs_lane.sv =====
// one lane of run edge detection over a slice of bitmap columns
// depends on brrs_pkg
module brrs_lane (
  input  logic [brrs_pkg::LANE_COLS-1:0] seg,
  input  logic                           left_bit,
  output brrs_pkg::lane_flags_t          flags
);
  import brrs_pkg::*;

  // left neighbor of each column, first one comes from the previous lane
  logic [LANE_COLS-1:0] prev;
  assign prev = {seg[LANE_COLS-2:0], left_bit};

  // run opens on a rising edge, closes on a falling edge
  assign flags.start = seg & ~prev;
  assign flags.stop  = ~seg & prev;

endmodule

// ===== rtl/core/brrs_merge.sv =====
// merge stage: walks the lane edge flags one column a cycle unless stalled
// by a full output, building a rectangle for each closed run; depends on brrs_pkg
module brrs_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [brrs_pkg::ROW_WIDTH-1:0] start_mask,
  input  logic [brrs_pkg::ROW_WIDTH:0]   stop_mask,
  input  brrs_pkg::item_t                item,
  input  logic [brrs_pkg::SCALE_W-1:0]   scale,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_ready,
  output brrs_pkg::rect_t                rect
);
  import brrs_pkg::*;

  logic [ROW_WIDTH-1:0]       start_sr;
  logic [ROW_WIDTH:0]         stop_sr;
  logic [COL_W-1:0]           col;
  logic [COL_W-1:0]           run_start;
  item_t                      item_q;
  logic [SCALE_W-1:0]         scale_q;

  logic                       slot_free;
  logic                       emit;
  logic                       advance;
  logic [COL_W-1:0]           len;
  logic [COL_W+SCALE_W-1:0]   width_full;
  logic [COL_W+SCALE_W-1:0]   x_off;
  logic [ROWNUM_W+SCALE_W-1:0] y_off;
  logic [RWIDTH_W-1:0]        width_sat;
  logic signed [COORD_W-1:0]  px;
  logic signed [COORD_W-1:0]  py;

  // scan control: stall only when a run closes and the output is full
  assign busy      = |stop_sr;
  assign slot_free = !out_valid || out_ready;
  assign emit      = stop_sr[0] && slot_free;
  assign advance   = busy && (!stop_sr[0] || slot_free);

  // rectangle geometry for the run closing at the current column
  assign len        = col - run_start;
  assign width_full = {{SCALE_W{1'b0}}, len} * {{COL_W{1'b0}}, scale_q};
  assign width_sat  = (width_full > (COL_W+SCALE_W)'(WIDTH_MAX)) ?
                      RWIDTH_W'(WIDTH_MAX) : width_full[RWIDTH_W-1:0];
  assign x_off      = {{SCALE_W{1'b0}}, run_start} * {{COL_W{1'b0}}, scale_q};
  assign y_off      = {{SCALE_W{1'b0}}, item_q.row_number} *
                      {{ROWNUM_W{1'b0}}, scale_q};
  assign px         = COORD_W'(item_q.origin_x) + COORD_W'(x_off);
  assign py         = COORD_W'(item_q.origin_y) + COORD_W'(y_off);

  // column walker and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_sr   <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        start_sr <= start_mask;
        stop_sr  <= stop_mask;
        col      <= '0;
        item_q   <= item;
        scale_q  <= scale;
      end else if (advance) begin
        start_sr <= start_sr >> 1;
        stop_sr  <= stop_sr >> 1;
        col      <= col + COL_W'(1);
        if (start_sr[0]) begin
          run_start <= col;
        end
      end

      if (emit) begin
        out_valid   <= 1'b1;
        rect.x      <= px;
        rect.y      <= py;
        rect.width  <= width_sat;
        rect.height <= scale_q;
        rect.colour <= item_q.fill_colour;
        // no run opens after this column
        rect.last   <= ~|start_sr;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/bitmap_row_run_spans.sv =====
// An item is one 24-column bitmap row; the block answers with one filled
// rectangle per run of set bits, last_run marking the final one, and nothing
// for an empty row. Four lanes find the run edges of their six columns in the
// cycle an item is accepted; the merge stage then walks one column a cycle,
// starting at column 0, up to and including the column that closes the last
// run, and pauses while a closed run waits on a full output register. A run
// touching the right edge closes at column 24. A new row is taken once the
// walk of the previous one ends, even while its last rectangle waits at the
// output. pixel_scale (reset 4) is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while idle, which the block does not enforce;
// zero acts as one and values above sixteen act as sixteen.
// Depends on brrs_pkg, brrs_lane, brrs_merge and the assertion macro header.
`include "bitmap_row_run_spans_defines.svh"

module bitmap_row_run_spans (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [brrs_pkg::SCALE_W-1:0]         cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [brrs_pkg::BITS_W-1:0]          row_bits,
  input  logic [brrs_pkg::ROWNUM_W-1:0]        row_number,
  input  logic signed [brrs_pkg::ORIGIN_W-1:0] origin_x,
  input  logic signed [brrs_pkg::ORIGIN_W-1:0] origin_y,
  input  logic [brrs_pkg::COLOUR_W-1:0]        fill_colour,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [brrs_pkg::COORD_W-1:0]  rect_x,
  output logic signed [brrs_pkg::COORD_W-1:0]  rect_y,
  output logic [brrs_pkg::RWIDTH_W-1:0]        rect_width,
  output logic [brrs_pkg::SCALE_W-1:0]         rect_height,
  output logic [brrs_pkg::COLOUR_W-1:0]        rect_colour,
  output logic                                 last_run
);
  import brrs_pkg::*;

  logic [SCALE_W-1:0]   pixel_scale;
  logic [ROW_WIDTH-1:0] col_bits;
  logic [ROW_WIDTH-1:0] start_mask;
  logic [ROW_WIDTH-1:0] stop_lanes;
  logic [ROW_WIDTH:0]   stop_mask;
  lane_flags_t          flags [NUM_LANES];
  item_t                item;
  rect_t                rect;
  logic                 busy;
  logic                 load;
  logic                 height_ok;

  // scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_scale <= SCALE_W'(SCALE_RESET);
    end else if (cfg_wr_en) begin
      pixel_scale <= cfg_wr_data;
    end
  end

  // columns in scan order, leftmost first; columns past the field read zero
  for (genvar c = 0; c < ROW_WIDTH; c++) begin : g_col
    if (ROW_WIDTH - 1 - c < BITS_W) begin : g_in
      assign col_bits[c] = row_bits[ROW_WIDTH-1-c];
    end else begin : g_pad
      assign col_bits[c] = 1'b0;
    end
  end

  // edge detection lanes
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    if (l == 0) begin : g_first
      brrs_lane u_lane (
        .seg      (col_bits[0 +: LANE_COLS]),
        .left_bit (1'b0),
        .flags    (flags[l])
      );
    end else begin : g_rest
      brrs_lane u_lane (
        .seg      (col_bits[l*LANE_COLS +: LANE_COLS]),
        .left_bit (col_bits[l*LANE_COLS-1]),
        .flags    (flags[l])
      );
    end
    assign start_mask[l*LANE_COLS +: LANE_COLS] = flags[l].start;
    assign stop_lanes[l*LANE_COLS +: LANE_COLS] = flags[l].stop;
  end

  // a run reaching the right edge closes at the column past the row
  assign stop_mask = {col_bits[ROW_WIDTH-1], stop_lanes};

  assign item     = '{row_number:  row_number,
                      origin_x:    origin_x,
                      origin_y:    origin_y,
                      fill_colour: fill_colour};
  assign in_ready = !busy;
  assign load     = in_valid && in_ready;

  brrs_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .start_mask (start_mask),
    .stop_mask  (stop_mask),
    .item       (item),
    .scale      (eff_scale(pixel_scale)),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rect       (rect)
  );

  assign rect_x      = rect.x;
  assign rect_y      = rect.y;
  assign rect_width  = rect.width;
  assign rect_height = rect.height;
  assign rect_colour = rect.colour;
  assign last_run    = rect.last;

  // rectangle height within the clamped scale range
  assign height_ok = (rect_height != '0) && (rect_height <= SCALE_W'(SCALE_MAX));

  // a row with set bits leaves the scanner busy in the cycle after it is accepted
  `BRRS_ASSERT_NEXT(a_busy_after_row, load && (row_bits != '0), !in_ready, "row not scanned")
  // an empty row leaves the block ready at once
  `BRRS_ASSERT_NEXT(a_empty_row_ready, load && (row_bits == '0), in_ready, "empty row held")
  // every rectangle carries a clamped scale
  `BRRS_ASSERT_SAME(a_height_range, out_valid, height_ok, "rect height out of range")

endmodule

// ===== tb/bitmap_row_run_spans_tb.sv =====
// self-checking testbench for bitmap_row_run_spans: random and directed bitmap rows,
// rectangles predicted in a scoreboard class and compared field by field
// depends on brrs_pkg and the bitmap_row_run_spans rtl
module bitmap_row_run_spans_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brrs_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ROWS   = 18;
  localparam int MAX_GAP      = 17;
  localparam longint TIMEOUT_NS = 1_000_000;

  // one bitmap row with its placement
  typedef struct packed {
    logic [BITS_W-1:0]          bits;
    logic [ROWNUM_W-1:0]        row;
    logic signed [ORIGIN_W-1:0] ox;
    logic signed [ORIGIN_W-1:0] oy;
    logic [COLOUR_W-1:0]        colour;
  } row_item_t;

  // rectangle prediction and result checking
  class span_scoreboard;
    rect_t rects_due[$];
    logic [SCALE_W-1:0] scale_reg;
    int rows_taken;
    int rects_checked;
    int errors;

    function new();
      scale_reg = SCALE_W'(SCALE_RESET);
      rows_taken = 0;
      rects_checked = 0;
      errors = 0;
    endfunction

    // zero acts as one, large values clamp
    function int applied_scale();
      if (scale_reg == '0) return 1;
      if (int'(scale_reg) > SCALE_MAX) return SCALE_MAX;
      return int'(scale_reg);
    endfunction

    // scan the row left to right, one rectangle per run of set columns
    function void add_row(row_item_t it);
      int s;
      int w;
      int start;
      bit in_run;
      bit px;
      bit have_prev;
      rect_t r;
      rect_t prev;
      s = applied_scale();
      in_run = 1'b0;
      start = 0;
      have_prev = 1'b0;
      prev = '0;
      for (int col = 0; col <= ROW_WIDTH; col++) begin
        px = 1'b0;
        if (col < ROW_WIDTH && ROW_WIDTH - 1 - col < BITS_W) px = it.bits[ROW_WIDTH-1-col];
        if (px) begin
          if (!in_run) begin
            in_run = 1'b1;
            start = col;
          end
        end else if (in_run) begin
          w = (col - start) * s;
          if (w > WIDTH_MAX) w = WIDTH_MAX;
          r.x = COORD_W'(int'($signed(it.ox)) + start * s);
          r.y = COORD_W'(int'($signed(it.oy)) + int'(it.row) * s);
          r.width = RWIDTH_W'(w);
          r.height = SCALE_W'(s);
          r.colour = it.colour;
          r.last = 1'b0;
          if (have_prev) rects_due.push_back(prev);
          prev = r;
          have_prev = 1'b1;
          in_run = 1'b0;
        end
      end
      // final run of the row carries the last flag
      if (have_prev) begin
        prev.last = 1'b1;
        rects_due.push_back(prev);
      end
      rows_taken++;
    endfunction

    // compare one accepted rectangle with the oldest one due
    function void check_rect(rect_t got);
      rect_t want;
      if (rects_due.size() == 0) begin
        $error("rectangle x=%0d y=%0d w=%0d arrived with no row pending",
               got.x, got.y, got.width);
        errors++;
        return;
      end
      want = rects_due.pop_front();
      rects_checked++;
      if (got.x !== want.x) begin
        $error("rect_x: expected %0d, got %0d", want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("rect_y: expected %0d, got %0d", want.y, got.y);
        errors++;
      end
      if (got.width !== want.width) begin
        $error("rect_width: expected %0d, got %0d", want.width, got.width);
        errors++;
      end
      if (got.height !== want.height) begin
        $error("rect_height: expected %0d, got %0d", want.height, got.height);
        errors++;
      end
      if (got.colour !== want.colour) begin
        $error("rect_colour: expected 0x%04h, got 0x%04h", want.colour, got.colour);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_run: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        cfg_wr_en;
  logic [SCALE_W-1:0]          cfg_wr_data;
  logic                        in_valid;
  logic                        in_ready;
  logic [BITS_W-1:0]           row_bits;
  logic [ROWNUM_W-1:0]         row_number;
  logic signed [ORIGIN_W-1:0]  origin_x;
  logic signed [ORIGIN_W-1:0]  origin_y;
  logic [COLOUR_W-1:0]         fill_colour;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [COORD_W-1:0]   rect_x;
  logic signed [COORD_W-1:0]   rect_y;
  logic [RWIDTH_W-1:0]         rect_width;
  logic [SCALE_W-1:0]          rect_height;
  logic [COLOUR_W-1:0]         rect_colour;
  logic                        last_run;

  span_scoreboard sb;
  bit idle_on;
  bit hold_req;
  int settings_used;

  bitmap_row_run_spans dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .row_bits    (row_bits),
    .row_number  (row_number),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .fill_colour (fill_colour),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .rect_colour (rect_colour),
    .last_run    (last_run)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // wait cycles before an item, none in quiet phases
  function automatic int draw_gap();
    if (!idle_on) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return int'($urandom_range(0, MAX_GAP));
  endfunction

  function automatic row_item_t make_row(logic [BITS_W-1:0] bits, logic [ROWNUM_W-1:0] row,
                                         logic signed [ORIGIN_W-1:0] ox,
                                         logic signed [ORIGIN_W-1:0] oy,
                                         logic [COLOUR_W-1:0] colour);
    row_item_t it;
    it.bits = bits;
    it.row = row;
    it.ox = ox;
    it.oy = oy;
    it.colour = colour;
    return it;
  endfunction

  // mix of empty, full, single-run, sparse, striped and dense rows
  function automatic logic [BITS_W-1:0] random_bits();
    int unsigned first;
    int unsigned len;
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 32'hFF_FFFF;
      2: begin
        first = $urandom_range(0, BITS_W - 1);
        len = $urandom_range(1, BITS_W - first);
        v = ((32'd1 << len) - 32'd1) << (BITS_W - first - len);
      end
      3, 4: v = $urandom & $urandom & $urandom;
      5: v = 32'hAA_AAAA >> $urandom_range(0, 1);
      default: v = $urandom;
    endcase
    return v[BITS_W-1:0];
  endfunction

  function automatic row_item_t random_row();
    return make_row(random_bits(), ROWNUM_W'($urandom_range(0, 31)), ORIGIN_W'($urandom),
                    ORIGIN_W'($urandom), COLOUR_W'($urandom));
  endfunction

  // offer one row, hold it until accepted
  task automatic send_row(input row_item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    row_bits <= it.bits;
    row_number <= it.row;
    origin_x <= it.ox;
    origin_y <= it.oy;
    fill_colour <= it.colour;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.add_row(it);
  endtask

  // wait for all rectangles and the end of any walk, then write the scale
  task automatic set_scale(input logic [SCALE_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.rects_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.scale_reg = value;
    settings_used++;
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    rect_t got;
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.x = rect_x;
      got.y = rect_y;
      got.width = rect_width;
      got.height = rect_height;
      got.colour = rect_colour;
      got.last = last_run;
      sb.check_rect(got);
    end
  end

  // stimulus
  initial begin
    row_item_t directed[$];
    logic [SCALE_W-1:0] scale_plan[$];
    sb = new();
    idle_on = 1'b1;
    hold_req = 1'b0;
    settings_used = 1;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    row_bits <= '0;
    row_number <= '0;
    origin_x <= '0;
    origin_y <= '0;
    fill_colour <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty rows, full rows, edge runs, most runs, origin and row extremes
    directed.push_back(make_row(24'h00_0000, 5'd0, 10'sd0, 10'sd0, 16'h1234));
    directed.push_back(make_row(24'hFF_FFFF, 5'd0, -10'sd512, -10'sd512, 16'h0000));
    directed.push_back(make_row(24'hFF_FFFF, 5'd31, 10'sd511, 10'sd511, 16'hFFFF));
    directed.push_back(make_row(24'h80_0000, 5'd1, 10'sd3, -10'sd7, 16'hF800));
    directed.push_back(make_row(24'h00_0001, 5'd2, -10'sd1, 10'sd9, 16'h07E0));
    directed.push_back(make_row(24'hAA_AAAA, 5'd23, 10'sd100, 10'sd200, 16'h001F));
    directed.push_back(make_row(24'h55_5555, 5'd24, -10'sd300, 10'sd400, 16'hA5A5));
    directed.push_back(make_row(24'h80_0001, 5'd5, 10'sd511, -10'sd512, 16'h5A5A));
    directed.push_back(make_row(24'hF0_000F, 5'd10, -10'sd512, 10'sd511, 16'hFFFF));
    directed.push_back(make_row(24'h00_0000, 5'd23, -10'sd1, -10'sd1, 16'h0001));
    directed.push_back(make_row(24'h7F_FFFE, 5'd17, 10'sd0, -10'sd1, 16'h8000));
    directed.push_back(make_row(24'h00_FF00, 5'd23, -10'sd1, -10'sd1, 16'hC3C3));

    // directed rows at the reset scale, then at the clamped maximum
    foreach (directed[i]) send_row(directed[i]);
    set_scale(5'd31);
    foreach (directed[i]) send_row(directed[i]);

    // random phases over scale settings; two quiet phases, the first with a long output hold
    scale_plan = '{5'd1, 5'd16, 5'd0, 5'd17, 5'd7, 5'd2, 5'd16, SCALE_W'($urandom_range(0, 31))};
    foreach (scale_plan[ph]) begin
      set_scale(scale_plan[ph]);
      idle_on = (ph % 3) != 2;
      if (ph == 2) hold_req = 1'b1;
      repeat (PHASE_ROWS) send_row(random_row());
    end
    in_valid <= 1'b0;

    // drain
    while (sb.rects_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d rows and %0d rectangles over %0d scale settings,",
             sb.rows_taken, sb.rects_checked, settings_used);
    $display("with random stalls on both sides and one long output hold");
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run time limit
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/brrs_pkg.sv
rtl/core/brrs_lane.sv
rtl/core/brrs_merge.sv
rtl/core/bitmap_row_run_spans.sv
tb/bitmap_row_run_spans_tb.sv
